// ----- design/harq_tx_process_fsm_defines.svh -----
// Assertion macros used by the event decoder of the transmit process.
`ifndef HARQ_TX_PROCESS_FSM_DEFINES_SVH
`define HARQ_TX_PROCESS_FSM_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HARQ_TX_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define HARQ_TX_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/harq_tx_pkg.sv -----
// Package: codes, types and helpers of the HARQ transmit process.
package harq_tx_pkg;

   localparam int StatAttempts = 4;
   localparam int DirLimit     = 4;
   localparam int StatW        = 32;
   localparam int AttIdxW      = (StatAttempts > 1) ? $clog2(StatAttempts) : 1;

   localparam logic [2:0] FuncInsert    = 3'd0;
   localparam logic [2:0] FuncSelect    = 3'd1;
   localparam logic [2:0] FuncExtract   = 3'd2;
   localparam logic [2:0] FuncAck       = 3'd3;
   localparam logic [2:0] FuncNack      = 3'd4;
   localparam logic [2:0] FuncSelfNack  = 3'd5;
   localparam logic [2:0] FuncDrop      = 3'd6;
   localparam logic [2:0] FuncForceDrop = 3'd7;

   localparam logic [1:0] StEmpty    = 2'd0;
   localparam logic [1:0] StSelected = 2'd1;
   localparam logic [1:0] StWaiting  = 2'd2;
   localparam logic [1:0] StBuffered = 2'd3;

   localparam logic [3:0] ErrNone        = 4'd0;
   localparam logic [3:0] ErrBusyInsert  = 4'd1;
   localparam logic [3:0] ErrCwMismatch  = 4'd2;
   localparam logic [3:0] ErrSelectIdle  = 4'd3;
   localparam logic [3:0] ErrExtractIdle = 4'd4;
   localparam logic [3:0] ErrFbIdle      = 4'd5;
   localparam logic [3:0] ErrSnWaiting   = 4'd6;
   localparam logic [3:0] ErrSnIdle      = 4'd7;
   localparam logic [3:0] ErrDropIdle    = 4'd8;

   localparam logic [1:0] CsrMaxRetx    = 2'd0;
   localparam logic [1:0] CsrCodeword   = 2'd1;
   localparam logic [1:0] CsrBaseStation = 2'd2;

   typedef struct packed {
      logic       valid;
      logic       nack;
      logic [3:0] ntx;
      logic       dir;
   } fb_type;

   typedef struct packed {
      logic [3:0]  error_code;
      logic        rtx_request;
      logic        discarded;
      logic        unit_freed;
      logic [15:0] pdu_out;
      logic        new_data;
      logic [3:0]  tx_number;
      logic [1:0]  unit_state;
   } base_type;

   typedef struct packed {
      logic [StatW-1:0] dir_total;
      logic [StatW-1:0] dir_nack_total;
      logic [StatW-1:0] attempt_total;
      logic [StatW-1:0] attempt_nack_total;
   } stat_type;

   function automatic logic [StatW-1:0] sat_inc(input logic [StatW-1:0] v, input logic inc);
      logic [StatW-1:0] r;
      r = v;
      if (inc && !(&v)) begin
         r = v + StatW'(1);
      end
      return r;
   endfunction

endpackage

// ----- design/harq_tx_event.sv -----
// Event decoder and process state registers of the HARQ transmit process.
`include "harq_tx_process_fsm_defines.svh"

module harq_tx_event (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic [2:0]           func,
   input  logic [15:0]          pdu_handle,
   input  logic                 pdu_codeword,
   input  logic                 pdu_direction,
   input  logic [3:0]           max_retx,
   input  logic                 unit_codeword,
   input  logic                 is_base_station,
   output harq_tx_pkg::base_type res,
   output harq_tx_pkg::fb_type   fb
);

   logic [1:0]  state_ff, state_in;
   logic [3:0]  tx_count_ff, tx_count_in;
   logic [15:0] held_pdu_ff;
   logic        held_dir_ff;
   logic        load;
   logic [3:0]  tx_sat;

   assign tx_sat = (tx_count_ff == 4'hF) ? tx_count_ff : tx_count_ff + 4'd1;

   always_comb begin
      state_in    = state_ff;
      tx_count_in = tx_count_ff;
      load        = 1'b0;
      fb          = '0;
      res         = '0;
      unique case (func)
         harq_tx_pkg::FuncInsert: begin
            if (state_ff != harq_tx_pkg::StEmpty) begin
               res.error_code = harq_tx_pkg::ErrBusyInsert;
            end else if (pdu_codeword != unit_codeword) begin
               res.error_code = harq_tx_pkg::ErrCwMismatch;
            end else begin
               load        = 1'b1;
               tx_count_in = 4'd0;
               state_in    = harq_tx_pkg::StSelected;
            end
         end
         harq_tx_pkg::FuncSelect: begin
            if (state_ff != harq_tx_pkg::StBuffered) begin
               res.error_code = harq_tx_pkg::ErrSelectIdle;
            end else begin
               state_in = harq_tx_pkg::StSelected;
            end
         end
         harq_tx_pkg::FuncExtract: begin
            if (state_ff != harq_tx_pkg::StSelected) begin
               res.error_code = harq_tx_pkg::ErrExtractIdle;
            end else begin
               tx_count_in  = tx_sat;
               state_in     = harq_tx_pkg::StWaiting;
               res.new_data = (tx_sat == 4'd1);
               res.pdu_out  = held_pdu_ff;
            end
         end
         harq_tx_pkg::FuncAck, harq_tx_pkg::FuncNack: begin
            if (state_ff != harq_tx_pkg::StWaiting) begin
               res.error_code = harq_tx_pkg::ErrFbIdle;
            end else begin
               fb.valid = 1'b1;
               fb.nack  = (func == harq_tx_pkg::FuncNack);
               fb.ntx   = tx_count_ff;
            end
         end
         harq_tx_pkg::FuncSelfNack: begin
            if (state_ff == harq_tx_pkg::StWaiting) begin
               res.error_code = harq_tx_pkg::ErrSnWaiting;
            end else if (state_ff != harq_tx_pkg::StBuffered) begin
               res.error_code = harq_tx_pkg::ErrSnIdle;
            end else begin
               tx_count_in = tx_sat;
               fb.valid    = 1'b1;
               fb.nack     = 1'b1;
               fb.ntx      = tx_sat;
            end
         end
         harq_tx_pkg::FuncDrop: begin
            if (state_ff != harq_tx_pkg::StBuffered) begin
               res.error_code = harq_tx_pkg::ErrDropIdle;
            end else begin
               res.pdu_out = held_pdu_ff;
               state_in    = harq_tx_pkg::StEmpty;
               tx_count_in = 4'd0;
            end
         end
         default: begin
            if (state_ff != harq_tx_pkg::StEmpty) begin
               res.pdu_out = held_pdu_ff;
            end
            state_in    = harq_tx_pkg::StEmpty;
            tx_count_in = 4'd0;
         end
      endcase

      // resolve feedback: free on ACK or at the limit, else buffer
      fb.dir = held_dir_ff;
      if (fb.valid) begin
         res.pdu_out = held_pdu_ff;
         if (!fb.nack) begin
            state_in       = harq_tx_pkg::StEmpty;
            tx_count_in    = 4'd0;
            res.unit_freed = 1'b1;
         end else if ({1'b0, fb.ntx} == ({1'b0, max_retx} + 5'd1)) begin
            state_in       = harq_tx_pkg::StEmpty;
            tx_count_in    = 4'd0;
            res.unit_freed = 1'b1;
            res.discarded  = 1'b1;
         end else begin
            state_in        = harq_tx_pkg::StBuffered;
            res.rtx_request = is_base_station;
         end
      end

      res.unit_state = state_in;
      res.tx_number  = tx_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= harq_tx_pkg::StEmpty;
         tx_count_ff <= 4'd0;
      end else if (en) begin
         state_ff    <= state_in;
         tx_count_ff <= tx_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && load) begin
         held_pdu_ff <= pdu_handle;
         held_dir_ff <= pdu_direction;
      end
   end

   `HARQ_TX_ASSERT_NEXT(a_err_holds_state, en && (res.error_code != harq_tx_pkg::ErrNone), (state_ff == $past(state_ff)) && (tx_count_ff == $past(tx_count_ff)), "error changed the process state")
   `HARQ_TX_ASSERT_NOW(a_empty_no_tx, state_ff == harq_tx_pkg::StEmpty, tx_count_ff == 4'd0, "empty unit with nonzero transmission count")
   `HARQ_TX_ASSERT_NOW(a_fb_legal, en && fb.valid, (state_ff == harq_tx_pkg::StWaiting) || ((state_ff == harq_tx_pkg::StBuffered) && (func == harq_tx_pkg::FuncSelfNack)), "feedback from an illegal state")
   `HARQ_TX_ASSERT_NEXT(a_freed_empty, en && res.unit_freed, state_ff == harq_tx_pkg::StEmpty, "freed unit not empty")

endmodule

// ----- design/harq_tx_stats.sv -----
// Saturating feedback and NACK statistics per attempt number and per direction.
module harq_tx_stats (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  harq_tx_pkg::fb_type   fb,
   output harq_tx_pkg::stat_type stat
);

   logic [harq_tx_pkg::StatW-1:0] att_nack_ff [harq_tx_pkg::StatAttempts];
   logic [harq_tx_pkg::StatW-1:0] att_nack_in [harq_tx_pkg::StatAttempts];
   logic [harq_tx_pkg::StatW-1:0] att_fb_ff   [harq_tx_pkg::StatAttempts];
   logic [harq_tx_pkg::StatW-1:0] att_fb_in   [harq_tx_pkg::StatAttempts];
   logic [harq_tx_pkg::StatW-1:0] dir_nack_ff [2];
   logic [harq_tx_pkg::StatW-1:0] dir_nack_in [2];
   logic [harq_tx_pkg::StatW-1:0] dir_fb_ff   [2];
   logic [harq_tx_pkg::StatW-1:0] dir_fb_in   [2];

   logic [3:0]                     k_full;
   logic [harq_tx_pkg::AttIdxW-1:0] k;
   logic                           att_hit;
   logic                           dir_lt;
   logic                           dir_eq;
   logic [harq_tx_pkg::StatW-1:0]  att_nack_new;
   logic [harq_tx_pkg::StatW-1:0]  att_fb_new;
   logic [harq_tx_pkg::StatW-1:0]  dir_nack_new;
   logic [harq_tx_pkg::StatW-1:0]  dir_fb_new;

   assign k_full  = fb.ntx - 4'd1;
   assign k       = k_full[harq_tx_pkg::AttIdxW-1:0];
   assign att_hit = (fb.ntx >= 4'd1) && (fb.ntx <= 4'(harq_tx_pkg::StatAttempts));
   assign dir_lt  = fb.ntx < 4'(harq_tx_pkg::DirLimit);
   assign dir_eq  = fb.ntx == 4'(harq_tx_pkg::DirLimit);

   assign att_nack_new = harq_tx_pkg::sat_inc(att_nack_ff[k], fb.nack);
   assign att_fb_new   = harq_tx_pkg::sat_inc(att_fb_ff[k], 1'b1);
   assign dir_nack_new = dir_lt ? harq_tx_pkg::sat_inc(dir_nack_ff[fb.dir], fb.nack)
                                : dir_nack_ff[fb.dir];
   assign dir_fb_new   = (dir_lt || dir_eq) ? harq_tx_pkg::sat_inc(dir_fb_ff[fb.dir], 1'b1)
                                            : dir_fb_ff[fb.dir];

   always_comb begin
      att_nack_in = att_nack_ff;
      att_fb_in   = att_fb_ff;
      dir_nack_in = dir_nack_ff;
      dir_fb_in   = dir_fb_ff;
      if (fb.valid && att_hit) begin
         att_nack_in[k] = att_nack_new;
         att_fb_in[k]   = att_fb_new;
      end
      if (fb.valid) begin
         dir_nack_in[fb.dir] = dir_nack_new;
         dir_fb_in[fb.dir]   = dir_fb_new;
      end
   end

   assign stat.attempt_nack_total = (fb.valid && att_hit) ? att_nack_new : '0;
   assign stat.attempt_total      = (fb.valid && att_hit) ? att_fb_new : '0;
   assign stat.dir_nack_total     = fb.valid ? dir_nack_new : '0;
   assign stat.dir_total          = fb.valid ? dir_fb_new : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < harq_tx_pkg::StatAttempts; i++) begin
            att_nack_ff[i] <= '0;
            att_fb_ff[i]   <= '0;
         end
         for (int j = 0; j < 2; j++) begin
            dir_nack_ff[j] <= '0;
            dir_fb_ff[j]   <= '0;
         end
      end else if (en) begin
         att_nack_ff <= att_nack_in;
         att_fb_ff   <= att_fb_in;
         dir_nack_ff <= dir_nack_in;
         dir_fb_ff   <= dir_fb_in;
      end
   end

endmodule

// ----- design/harq_tx_process_fsm.sv -----
// Top level of one stop-and-wait HARQ transmit process.
//
// Requests arrive on the req_ channel, one event each (kind in req_tuser,
// PDU handle, codeword and direction in req_tdata). Every request gives
// exactly one response on the rsp_ channel with the new process state,
// the transmission count, the released handle, flags, an error code and
// the NACK statistics after any feedback.
// A request is first held in the input register, then decoded, and its
// response is registered in the output register, which drives
// rsp_tvalid. Throughput is one request per cycle without stalls: the
// process state and statistics update in the same cycle as the decode.
// When the receiver stalls the response register holds and the input
// register still takes one more request; req_tready drops only when both
// are full. Reset clears both stages, the process state (empty, no
// transmissions), the statistics, and loads max_retx 3, codeword 0 and
// base station mode. Write the csr_ registers only while no request is
// in flight.
module harq_tx_process_fsm (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [2:0]   req_tuser,   // func
   input  logic [23:0]  req_tdata,   // pdu_handle, pdu_codeword, pdu_direction, zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // unit_state, tx_number, new_data, pdu_out, unit_freed, discarded, rtx_request,
   // error_code, attempt_nack_total, attempt_total, dir_nack_total, dir_total, zero pad
   output logic [159:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [3:0]   csr_wdata
);

   logic        in_valid_ff, in_valid_in;
   logic [2:0]  in_user_ff;
   logic [17:0] in_data_ff;
   logic        out_valid_ff, out_valid_in;
   logic [159:0] out_data_ff;
   logic        advance;
   logic        req_take;

   logic [3:0]  max_retx_ff;
   logic        unit_codeword_ff;
   logic        is_bs_ff;

   harq_tx_pkg::base_type base;
   harq_tx_pkg::fb_type   fb;
   harq_tx_pkg::stat_type stat;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_user_ff <= req_tuser;
         in_data_ff <= req_tdata[17:0];
      end
      if (advance) begin
         out_data_ff <= {2'b00, stat, base};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_retx_ff      <= 4'd3;
         unit_codeword_ff <= 1'b0;
         is_bs_ff         <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            harq_tx_pkg::CsrMaxRetx:     max_retx_ff      <= csr_wdata;
            harq_tx_pkg::CsrCodeword:    unit_codeword_ff <= csr_wdata[0];
            harq_tx_pkg::CsrBaseStation: is_bs_ff         <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   harq_tx_event u_event (
      .clock           (clock),
      .reset           (reset),
      .en              (advance),
      .func            (in_user_ff),
      .pdu_handle      (in_data_ff[15:0]),
      .pdu_codeword    (in_data_ff[16]),
      .pdu_direction   (in_data_ff[17]),
      .max_retx        (max_retx_ff),
      .unit_codeword   (unit_codeword_ff),
      .is_base_station (is_bs_ff),
      .res             (base),
      .fb              (fb)
   );

   harq_tx_stats u_stats (
      .clock (clock),
      .reset (reset),
      .en    (advance),
      .fb    (fb),
      .stat  (stat)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
